### hw/rtl/epra_pkg.sv
// Shared types and constants for the ECG peak rate alarm block.
// No dependencies; imported by every module of the block.
`default_nettype none

package epra_pkg;

    localparam int unsigned SAMPLE_W   = 16;
    localparam int unsigned TIME_W     = 32;
    localparam int unsigned BPM_W      = 16;
    localparam int unsigned ALARM_W    = 2;
    localparam int unsigned ADDR_W     = 5;
    localparam int unsigned DIV_STEPS  = 16;
    localparam int unsigned STEP_CNT_W = 4;
    localparam int unsigned PROD_W     = BPM_W + TIME_W;

    localparam logic [BPM_W-1:0] RATE_NUMERATOR    = 16'd60000;
    localparam logic [BPM_W-1:0] FORCED_NORMAL_BPM = 16'd75;
    localparam logic [BPM_W-1:0] FORCED_TACHY_BPM  = 16'd170;

    typedef enum logic [ALARM_W-1:0] {
        ALARM_NONE     = 2'd0,
        ALARM_ASYSTOLE = 2'd1,
        ALARM_TACHY    = 2'd2
    } alarm_t;

    typedef enum logic [2:0] {
        REG_PEAK_THRESHOLD = 3'd0,
        REG_ASYSTOLE_LIMIT = 3'd1,
        REG_TACHY_LIMIT    = 3'd2,
        REG_MIN_INTERVAL   = 3'd3,
        REG_FORCE_ENABLE   = 3'd4,
        REG_FORCE_LEVEL    = 3'd5,
        REG_FORCE_MAX      = 3'd6,
        REG_UNUSED         = 3'd7
    } reg_index_t;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_INIT,
        ST_DIV,
        ST_DONE
    } ctrl_state_t;

    typedef struct packed {
        logic signed [SAMPLE_W-1:0] peak_threshold;
        logic [15:0]                asystole_limit_ms;
        logic [15:0]                tachy_bpm_limit;
        logic [15:0]                min_interval_ms;
        logic                       force_enable;
        logic signed [SAMPLE_W-1:0] force_level;
        logic [15:0]                force_max_interval_ms;
    } cfg_t;

    typedef struct packed {
        logic load;
        logic init;
        logic step;
        logic finish;
    } dp_cmd_t;

    typedef struct packed {
        logic out_free;
    } dp_status_t;

endpackage

`default_nettype wire

### hw/rtl/ecg_peak_rate_alarm_top.sv
// Top level of the ECG R-peak rate and alarm block.
// Depends on epra_pkg, epra_cfg_regs, epra_ctrl and epra_datapath.
//
//  channel   dir   handshake                fields
//  s_axis    in    s_tvalid / s_tready      sample, time_ms
//  m_axis    out   m_tvalid / m_tready      sample_out, bpm, alarm
//  apb       in    psel/penable/pready      7 registers at 4*i
//
// Each word passes through accept, divider setup, 16 restoring divide steps
// for 60000 / interval, then commit into the output register.
// Reset clears the peak time, the armed flag and the output valid.
// A result waiting in the output register does not stop the next word from
// being accepted and divided; only the commit waits for m_tready.
`default_nettype none

module ecg_peak_rate_alarm_top (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        s_tvalid,
    output logic             s_tready,
    input  wire logic [47:0] s_tdata,  // sample[15:0], time_ms[47:16]
    output logic             m_tvalid,
    input  wire logic        m_tready,
    output logic [39:0]      m_tdata,  // sample_out[15:0], bpm[31:16], alarm[33:32], zero
    input  wire logic        psel,
    input  wire logic        penable,
    input  wire logic        pwrite,
    input  wire logic [4:0]  paddr,
    input  wire logic [31:0] pwdata,
    output logic [31:0]      prdata,
    output logic             pready
);
    import epra_pkg::*;

    cfg_t                cfg;
    dp_cmd_t             cmd;
    dp_status_t          status;
    logic [SAMPLE_W-1:0] out_sample;
    logic [BPM_W-1:0]    out_bpm;
    logic [ALARM_W-1:0]  out_alarm;

    assign m_tdata = {6'd0, out_alarm, out_bpm, out_sample};

    epra_cfg_regs u_cfg (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    epra_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (s_tvalid),
        .in_ready (s_tready),
        .status   (status),
        .cmd      (cmd)
    );

    epra_datapath u_dp (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg        (cfg),
        .cmd        (cmd),
        .status     (status),
        .in_sample  (s_tdata[15:0]),
        .in_time    (s_tdata[47:16]),
        .out_valid  (m_tvalid),
        .out_ready  (m_tready),
        .out_sample (out_sample),
        .out_bpm    (out_bpm),
        .out_alarm  (out_alarm)
    );

endmodule

`default_nettype wire

### hw/rtl/epra_cfg_regs.sv
// Configuration register file behind the APB-style port.
// Depends on epra_pkg for the register index codes and cfg_t.
`default_nettype none

module epra_cfg_regs (
    input  wire logic                       clk,
    input  wire logic                       rst_n,
    input  wire logic                       psel,
    input  wire logic                       penable,
    input  wire logic                       pwrite,
    input  wire logic [epra_pkg::ADDR_W-1:0] paddr,
    input  wire logic [31:0]                pwdata,
    output logic [31:0]                     prdata,
    output logic                            pready,
    output epra_pkg::cfg_t                  cfg
);
    import epra_pkg::*;

    cfg_t       cfg_reg;
    cfg_t       cfg_next;
    reg_index_t index;
    logic       wr_en;

    assign pready = 1'b1;
    assign index  = reg_index_t'(paddr[ADDR_W-1:2]);
    assign wr_en  = psel && penable && pwrite && pready;
    assign cfg    = cfg_reg;

    always_comb
    begin
        cfg_next = cfg_reg;
        if (wr_en)
        begin
            case (index)
                REG_PEAK_THRESHOLD: cfg_next.peak_threshold        = pwdata[15:0];
                REG_ASYSTOLE_LIMIT: cfg_next.asystole_limit_ms     = pwdata[15:0];
                REG_TACHY_LIMIT:    cfg_next.tachy_bpm_limit       = pwdata[15:0];
                REG_MIN_INTERVAL:   cfg_next.min_interval_ms       = pwdata[15:0];
                REG_FORCE_ENABLE:   cfg_next.force_enable          = pwdata[0];
                REG_FORCE_LEVEL:    cfg_next.force_level           = pwdata[15:0];
                REG_FORCE_MAX:      cfg_next.force_max_interval_ms = pwdata[15:0];
                default:            cfg_next = cfg_reg;
            endcase
        end
    end

    always_comb
    begin
        case (index)
            REG_PEAK_THRESHOLD: prdata = {16'd0, cfg_reg.peak_threshold};
            REG_ASYSTOLE_LIMIT: prdata = {16'd0, cfg_reg.asystole_limit_ms};
            REG_TACHY_LIMIT:    prdata = {16'd0, cfg_reg.tachy_bpm_limit};
            REG_MIN_INTERVAL:   prdata = {16'd0, cfg_reg.min_interval_ms};
            REG_FORCE_ENABLE:   prdata = {31'd0, cfg_reg.force_enable};
            REG_FORCE_LEVEL:    prdata = {16'd0, cfg_reg.force_level};
            REG_FORCE_MAX:      prdata = {16'd0, cfg_reg.force_max_interval_ms};
            default:            prdata = 32'd0;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.peak_threshold        <= 16'sd2048;
            cfg_reg.asystole_limit_ms     <= 16'd2500;
            cfg_reg.tachy_bpm_limit       <= 16'd140;
            cfg_reg.min_interval_ms       <= 16'd50;
            cfg_reg.force_enable          <= 1'b1;
            cfg_reg.force_level           <= 16'sd6144;
            cfg_reg.force_max_interval_ms <= 16'd400;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

endmodule

`default_nettype wire

### hw/rtl/epra_ctrl.sv
// Sequencer for one word: capture, divider setup, divide steps, commit.
// Depends on epra_pkg for the state enum and command/status structs.
`default_nettype none

module epra_ctrl (
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    input  wire logic                 in_valid,
    output logic                      in_ready,
    input  wire epra_pkg::dp_status_t status,
    output epra_pkg::dp_cmd_t         cmd
);
    import epra_pkg::*;

    ctrl_state_t           state_reg;
    ctrl_state_t           state_next;
    logic [STEP_CNT_W-1:0] step_cnt_reg;
    logic [STEP_CNT_W-1:0] step_cnt_next;
    logic                  last_step;

    assign last_step = (step_cnt_reg == STEP_CNT_W'(DIV_STEPS - 1));

    always_comb
    begin
        state_next    = state_reg;
        step_cnt_next = step_cnt_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (in_valid)
                begin
                    state_next = ST_INIT;
                end
            end
            ST_INIT:
            begin
                step_cnt_next = '0;
                state_next    = ST_DIV;
            end
            ST_DIV:
            begin
                step_cnt_next = step_cnt_reg + 1'b1;
                if (last_step)
                begin
                    state_next = ST_DONE;
                end
            end
            ST_DONE:
            begin
                if (status.out_free)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_comb
    begin
        cmd      = '0;
        in_ready = 1'b0;
        case (state_reg)
            ST_IDLE:
            begin
                in_ready = 1'b1;
                cmd.load = in_valid;
            end
            ST_INIT:
            begin
                cmd.init = 1'b1;
            end
            ST_DIV:
            begin
                cmd.step = 1'b1;
            end
            ST_DONE:
            begin
                cmd.finish = status.out_free;
            end
            default:
            begin
                cmd = '0;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= ST_IDLE;
            step_cnt_reg <= '0;
        end
        else
        begin
            state_reg    <= state_next;
            step_cnt_reg <= step_cnt_next;
        end
    end

endmodule

`default_nettype wire

### hw/rtl/epra_datapath.sv
// Datapath: word capture, interval, restoring rate divider, tachy product,
// peak state and the output register. Depends on epra_pkg.
`default_nettype none

module epra_datapath (
    input  wire logic                         clk,
    input  wire logic                         rst_n,
    input  wire epra_pkg::cfg_t               cfg,
    input  wire epra_pkg::dp_cmd_t            cmd,
    output epra_pkg::dp_status_t              status,
    input  wire logic [epra_pkg::SAMPLE_W-1:0] in_sample,
    input  wire logic [epra_pkg::TIME_W-1:0]   in_time,
    output logic                              out_valid,
    input  wire logic                         out_ready,
    output logic [epra_pkg::SAMPLE_W-1:0]     out_sample,
    output logic [epra_pkg::BPM_W-1:0]        out_bpm,
    output logic [epra_pkg::ALARM_W-1:0]      out_alarm
);
    import epra_pkg::*;

    logic signed [SAMPLE_W-1:0] sample_reg;
    logic [TIME_W-1:0]          time_reg;
    logic [TIME_W-1:0]          interval_reg;
    logic [PROD_W-1:0]          prod_reg;
    logic [BPM_W-1:0]           rem_reg;
    logic [BPM_W-1:0]           quo_reg;
    logic [TIME_W-1:0]          last_peak_reg;
    logic                       armed_reg;
    logic                       out_valid_reg;
    logic [SAMPLE_W-1:0]        out_sample_reg;
    logic [BPM_W-1:0]           out_bpm_reg;
    alarm_t                     out_alarm_reg;

    logic [BPM_W:0]             shifted;
    logic [BPM_W:0]             divisor;
    logic                       ge;
    logic                       forced;
    logic                       forced_tachy;
    logic                       asystole;
    logic                       rising;
    logic                       tachy;
    logic [BPM_W-1:0]           rate;
    logic [BPM_W-1:0]           bpm_next;
    alarm_t                     alarm_next;
    logic                       peak_next;
    logic                       armed_next;

    assign status.out_free = !out_valid_reg || out_ready;
    assign out_valid       = out_valid_reg;
    assign out_sample      = out_sample_reg;
    assign out_bpm         = out_bpm_reg;
    assign out_alarm       = out_alarm_reg;

    assign divisor = {1'b0, interval_reg[BPM_W-1:0]};
    assign shifted = {rem_reg, quo_reg[BPM_W-1]};
    assign ge      = (shifted >= divisor);

    always_comb
    begin
        forced       = cfg.force_enable && (sample_reg > cfg.force_level);
        forced_tachy = (interval_reg < {16'd0, cfg.force_max_interval_ms})
                       && (interval_reg > {16'd0, cfg.min_interval_ms});
        asystole     = interval_reg > {16'd0, cfg.asystole_limit_ms};
        rising       = (sample_reg > cfg.peak_threshold) && !armed_reg;
        tachy        = (interval_reg > {16'd0, cfg.min_interval_ms})
                       && (prod_reg < PROD_W'(RATE_NUMERATOR));
        if (interval_reg == '0)
        begin
            rate = RATE_NUMERATOR;
        end
        else if (interval_reg > TIME_W'(RATE_NUMERATOR))
        begin
            rate = '0;
        end
        else
        begin
            rate = quo_reg;
        end

        bpm_next   = '0;
        alarm_next = ALARM_NONE;
        peak_next  = 1'b0;
        armed_next = armed_reg;
        if (forced)
        begin
            peak_next = 1'b1;
            if (forced_tachy)
            begin
                bpm_next   = FORCED_TACHY_BPM;
                alarm_next = ALARM_TACHY;
            end
            else
            begin
                bpm_next = FORCED_NORMAL_BPM;
            end
        end
        else
        begin
            if (asystole)
            begin
                alarm_next = ALARM_ASYSTOLE;
                peak_next  = 1'b1;
            end
            if (rising)
            begin
                armed_next = 1'b1;
                peak_next  = 1'b1;
                bpm_next   = rate;
                if (tachy)
                begin
                    alarm_next = ALARM_TACHY;
                end
            end
            else if (sample_reg < cfg.peak_threshold)
            begin
                armed_next = 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        prod_reg <= PROD_W'(cfg.tachy_bpm_limit) * PROD_W'(interval_reg);
        if (cmd.load)
        begin
            sample_reg   <= in_sample;
            time_reg     <= in_time;
            interval_reg <= in_time - last_peak_reg;
        end
        if (cmd.init)
        begin
            rem_reg <= '0;
            quo_reg <= RATE_NUMERATOR;
        end
        else if (cmd.step)
        begin
            rem_reg <= ge ? BPM_W'(shifted - divisor) : shifted[BPM_W-1:0];
            quo_reg <= {quo_reg[BPM_W-2:0], ge};
        end
        if (cmd.finish)
        begin
            out_sample_reg <= sample_reg;
            out_bpm_reg    <= bpm_next;
            out_alarm_reg  <= alarm_next;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            last_peak_reg <= '0;
            armed_reg     <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (cmd.finish)
            begin
                armed_reg <= armed_next;
                if (peak_next)
                begin
                    last_peak_reg <= time_reg;
                end
            end
            if (cmd.finish)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

endmodule

`default_nettype wire
